// File: rtl/alcd_pkg.sv
// shared types and constants for the attention length command deframer
`default_nettype none

package alcd_pkg;

    // field widths
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned POS_W    = 9;
    localparam int unsigned HDR_W    = 4;
    localparam int unsigned CFG_IX_W = 2;

    // frame layout
    localparam logic [POS_W-1:0] LENGTH_POS = POS_W'(2);
    localparam logic [HDR_W-1:0] MAX_HEADER = HDR_W'(8);
    localparam logic [HDR_W-1:0] MIN_HEADER = HDR_W'(1);
    localparam logic [HDR_W-1:0] RST_HEADER = HDR_W'(3);

    // configuration register indexes
    typedef enum logic [CFG_IX_W-1:0] {
        CFG_ATTENTION  = 2'd0,
        CFG_ALT_ATTN   = 2'd1,
        CFG_ALT_ENABLE = 2'd2,
        CFG_HEADER     = 2'd3
    } t_cfg_index;

    // configuration register set
    typedef struct packed {
        logic [BYTE_W-1:0] attention_byte;
        logic [BYTE_W-1:0] alt_attention_byte;
        logic              alt_attention_enable;
        logic [HDR_W-1:0]  header_size;
    } t_cfg;

    // one result item
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] frame_byte;
        logic [POS_W-1:0]  byte_position;
        logic              frame_last;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/alcd_tracker.sv
// frame tracker: start detection, position count, length latch and end test
`default_nettype none

module alcd_tracker
    import alcd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic [BYTE_W-1:0] i_byte,
    input  wire t_cfg              i_cfg,
    output t_result                o_result
);

    logic [POS_W-1:0]  r_count;
    logic [BYTE_W-1:0] r_len;
    logic [POS_W-1:0]  n_count;
    logic [BYTE_W-1:0] n_len;
    logic [HDR_W-1:0]  hdr;
    logic [POS_W-1:0]  count_inc;
    logic [POS_W:0]    frame_end;
    logic              hunting;
    logic              is_start;
    logic              take;
    logic              last;

    // clamp header size into 1..8
    always_comb begin
        if (i_cfg.header_size == '0) begin
            hdr = MIN_HEADER;
        end else if (i_cfg.header_size > MAX_HEADER) begin
            hdr = MAX_HEADER;
        end else begin
            hdr = i_cfg.header_size;
        end
    end

    // start byte check while hunting
    assign hunting  = (r_count == '0);
    assign is_start = (i_byte == i_cfg.attention_byte) ||
                      (i_cfg.alt_attention_enable && (i_byte == i_cfg.alt_attention_byte));
    assign take     = !hunting || is_start;

    // length in force for this byte
    always_comb begin
        if (hunting) begin
            n_len = '0;
        end else if (r_count == LENGTH_POS) begin
            n_len = i_byte;
        end else begin
            n_len = r_len;
        end
    end

    // end of frame test against the current registers
    assign count_inc = r_count + POS_W'(1);
    assign frame_end = (POS_W+1)'(hdr) + (POS_W+1)'(n_len);
    assign last      = (count_inc >= POS_W'(hdr)) && ((POS_W+1)'(count_inc) >= frame_end);
    assign n_count   = last ? '0 : count_inc;

    // state update on each accepted transaction that belongs to a frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_len   <= '0;
        end else if (i_accept && take) begin
            r_count <= n_count;
            r_len   <= n_len;
        end
    end

    // result for the byte on the input
    always_comb begin
        o_result.valid         = i_accept && take;
        o_result.frame_byte    = i_byte;
        o_result.byte_position = r_count;
        o_result.frame_last    = last;
    end

endmodule

`default_nettype wire

// File: rtl/attention_length_command_deframer_top.sv
// top level of the attention length command deframer: ports, config registers, output register
//
//  channel   direction  handshake                       payload
//  s_axis    in         s_axis_tvalid / s_axis_tready   tdata: rx_byte
//  m_axis    out        m_axis_tvalid / m_axis_tready   tdata: frame_byte, byte_position; tlast
//  cfg       in         i_cfg_valid / o_cfg_ready       i_cfg_index, i_cfg_data
//
//  one byte per cycle; a result is registered and appears in the cycle after its byte is taken
//  the output register is the only stage, so s_axis_tready is low only while a
//  result is held and m_axis_tready is low
//  reset (synchronous, active low) returns to hunting, header size 3, start bytes 0
//  dropped bytes while hunting give no result
`default_nettype none

module attention_length_command_deframer_top
    import alcd_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // input stream
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [BYTE_W-1:0]   s_axis_tdata,   // [7:0] rx_byte
    // output stream
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [23:0]              m_axis_tdata,   // [7:0] frame_byte, [16:8] byte_position
    output logic                     m_axis_tlast,   // frame_last
    // configuration writes
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [CFG_IX_W-1:0] i_cfg_index,
    input  wire logic [BYTE_W-1:0]   i_cfg_data
);

    t_cfg              r_cfg;
    t_result           result;
    logic              accept;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic [POS_W-1:0]  r_out_pos;
    logic              r_out_last;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attention_byte       <= '0;
            r_cfg.alt_attention_byte   <= '0;
            r_cfg.alt_attention_enable <= 1'b0;
            r_cfg.header_size          <= RST_HEADER;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_ATTENTION:  r_cfg.attention_byte       <= i_cfg_data;
                CFG_ALT_ATTN:   r_cfg.alt_attention_byte   <= i_cfg_data;
                CFG_ALT_ENABLE: r_cfg.alt_attention_enable <= i_cfg_data[0];
                CFG_HEADER:     r_cfg.header_size          <= i_cfg_data[HDR_W-1:0];
                default: ;
            endcase
        end
    end

    // input transaction
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    alcd_tracker u_tracker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_axis_tdata),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    // output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_out_valid <= result.valid;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && result.valid) begin
            r_out_byte <= result.frame_byte;
            r_out_pos  <= result.byte_position;
            r_out_last <= result.frame_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_pos, r_out_byte};
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

// File: dv/tb.sv
// self-checking testbench for the attention length command deframer
`timescale 1ns / 1ps

module tb;
    import alcd_pkg::*;

    // one deframed byte as it leaves the block
    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic [POS_W-1:0]  byte_position;
        logic              frame_last;
    } t_deframed;

    localparam int N_PHASES        = 8;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int SETTLE_CYCLES   = 4;
    // idling per phase: none, sender only, receiver only, both
    localparam int SEND_IDLE_PCT [4] = '{0, 71, 0, 32};
    localparam int RECV_STALL_PCT[4] = '{0, 0, 71, 32};
    // header sizes per phase (phase 6 draws its own), out-of-range values included
    localparam logic [HDR_W-1:0] PHASE_HDR [N_PHASES] = '{
        4'd3, 4'd1, 4'd8, 4'd0, 4'd15, 4'd2, 4'd5, 4'd8
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata = '0;    // [7:0] rx_byte
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [23:0]           m_axis_tdata;         // [7:0] frame_byte, [16:8] byte_position
    logic                  m_axis_tlast;         // frame_last
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IX_W-1:0]   i_cfg_index = '0;
    logic [BYTE_W-1:0]     i_cfg_data = '0;

    // bytes waiting to be sent, and deframed bytes still to arrive
    logic [BYTE_W-1:0] rx_queue [$];
    t_deframed         expected_frames [$];
    int                mismatches = 0;
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;

    // predictor copy of the registers and the frame state
    logic [BYTE_W-1:0] cfg_attn = '0;
    logic [BYTE_W-1:0] cfg_alt = '0;
    logic              cfg_alt_en = 1'b0;
    logic [HDR_W-1:0]  cfg_hdr = RST_HEADER;
    logic [POS_W-1:0]  frame_cnt = '0;
    logic [BYTE_W-1:0] pay_len = '0;

    // register values the stimulus generator builds frames for
    logic [BYTE_W-1:0] g_attn = '0;
    logic [BYTE_W-1:0] g_alt = '0;
    logic              g_alt_en = 1'b0;
    logic [HDR_W-1:0]  g_hdr = RST_HEADER;

    attention_length_command_deframer_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // header size as the end test sees it: 0 acts as 1, above 8 acts as 8
    function automatic int unsigned eff_header(input logic [HDR_W-1:0] h);
        if (h == '0) return MIN_HEADER;
        if (h > MAX_HEADER) return MAX_HEADER;
        return h;
    endfunction

    // run one accepted byte through the frame tracker
    task automatic predict_byte(input logic [BYTE_W-1:0] b);
        t_deframed   item;
        int unsigned hdr;
        if (frame_cnt == '0) begin
            if (!(b == cfg_attn || (cfg_alt_en && b == cfg_alt))) return;
            pay_len = '0;
        end else if (frame_cnt == LENGTH_POS) begin
            pay_len = b;
        end
        item.frame_byte    = b;
        item.byte_position = frame_cnt;
        item.frame_last    = 1'b0;
        frame_cnt = frame_cnt + 1'b1;
        hdr = eff_header(cfg_hdr);
        if (frame_cnt >= hdr && frame_cnt >= hdr + pay_len) begin
            item.frame_last = 1'b1;
            frame_cnt = '0;
        end
        expected_frames.push_back(item);
    endtask

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
    endtask

    // one well-formed frame with random content, now and then cut short
    function automatic int queue_frame();
        int unsigned hdr, len, total, r;
        hdr = eff_header(g_hdr);
        r = $urandom_range(99);
        if (r < 3) len = 255;
        else if (r < 10) len = $urandom_range(255);
        else len = $urandom_range(12);
        total = (hdr > LENGTH_POS) ? hdr + len : hdr;
        // a short frame lets the next start byte fall inside it as data
        if (total > 1 && $urandom_range(19) == 0) total = $urandom_range(total - 1, 1);
        rx_queue.push_back((g_alt_en && $urandom_range(1) == 1) ? g_alt : g_attn);
        for (int unsigned k = 1; k < total; k++)
            rx_queue.push_back((k == LENGTH_POS) ? 8'(len) : 8'($urandom));
        return total;
    endfunction

    // wait until every byte is sent and every result has arrived
    task automatic wait_drained();
        do @(negedge i_clk);
        while (rx_queue.size() != 0 || s_axis_tvalid || expected_frames.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write all four registers back to back; called at a rising edge
    task automatic program_cfg(input logic [7:0] attn, input logic [7:0] alt,
                               input logic [7:0] alt_en, input logic [7:0] hdr);
        logic [7:0] vals [4];
        vals = '{attn, alt, alt_en, hdr};
        for (int k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= t_cfg_index'(k);
            i_cfg_data  <= vals[k];
            do @(posedge i_clk);
            while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        g_attn   = attn;
        g_alt    = alt;
        g_alt_en = alt_en[0];
        g_hdr    = hdr[HDR_W-1:0];
    endtask

    // byte driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (rx_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= rx_queue.pop_front();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result receiver with random stalls
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor: check results, feed the predictor, track register writes
    always @(posedge i_clk) begin : monitor
        t_deframed got, want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tdata[BYTE_W-1:0], m_axis_tdata[BYTE_W+POS_W-1:BYTE_W],
                        m_axis_tlast};
                if (expected_frames.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result: byte %02h pos %0d last %0b",
                                            got.frame_byte, got.byte_position,
                                            got.frame_last));
                end else begin
                    want = expected_frames.pop_front();
                    if (got !== want)
                        flag_mismatch($sformatf(
                            "expected byte %02h pos %0d last %0b, got byte %02h pos %0d last %0b",
                            want.frame_byte, want.byte_position, want.frame_last,
                            got.frame_byte, got.byte_position, got.frame_last));
                end
            end
            if (s_axis_tvalid && s_axis_tready) predict_byte(s_axis_tdata);
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_ATTENTION:  cfg_attn   = i_cfg_data;
                    CFG_ALT_ATTN:   cfg_alt    = i_cfg_data;
                    CFG_ALT_ENABLE: cfg_alt_en = i_cfg_data[0];
                    CFG_HEADER:     cfg_hdr    = i_cfg_data[HDR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // stimulus sequence
    initial begin
        int queued, noise;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset registers: junk dropped, zero-length frame, start byte taken as data
        rx_queue = '{8'hFF, 8'h00, 8'h11, 8'h00,
                     8'h00, 8'hAA, 8'h02, 8'h00, 8'hFF};
        wait_drained();
        // header 0 acts as 1: single-byte frames, alternate start byte enabled
        program_cfg(8'hFF, 8'h00, 8'h01, 8'h00);
        rx_queue = '{8'hFF, 8'h00, 8'h55};
        wait_drained();
        // header 2 ends before the length byte; alternate byte now dropped
        program_cfg(8'hFF, 8'h00, 8'h00, 8'h02);
        rx_queue = '{8'h00, 8'hFF, 8'h07};
        wait_drained();
        // header 15 acts as 8; leave the frame open at count 4
        program_cfg(8'hFF, 8'h00, 8'hFE, 8'hFF);
        rx_queue = '{8'hFF, 8'h01, 8'h00, 8'h80};
        wait_drained();
        // shrink the header mid-frame, so the next byte closes it
        program_cfg(8'h80, 8'h7F, 8'h01, 8'hA3);
        rx_queue = '{8'h7F};

        // random phases over several register settings and idling modes
        for (int p = 0; p < N_PHASES; p++) begin
            wait_drained();
            send_idle_pct  = SEND_IDLE_PCT[p % 4];
            recv_stall_pct = RECV_STALL_PCT[p % 4];
            program_cfg((p == 0) ? 8'h00 : (p == 1) ? 8'hFF : 8'($urandom),
                        (p == 2) ? 8'hFF : 8'($urandom),
                        {7'($urandom), 1'(p % 2)},
                        {4'($urandom), (p == 6) ? 4'($urandom) : PHASE_HDR[p]});
            queued = 0;
            while (queued < ITEMS_PER_PHASE) begin
                // line noise between frames
                if ($urandom_range(4) == 0) begin
                    noise = $urandom_range(3, 1);
                    repeat (noise) rx_queue.push_back(8'($urandom));
                    queued += noise;
                end
                queued += queue_frame();
            end
        end
        wait_drained();

        if (mismatches == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
